// File: src/tmmb_pkg.sv
// shared types and constants for the trimmed mean and median scorer
package tmmb_pkg;

	// field widths fixed by the item and result formats
	localparam int RATING_W = 12;
	localparam int FOLD_W   = 11;
	localparam int IDX_W    = 4;
	localparam int SUM_W    = 13;
	localparam int MEAN_W   = 14;
	localparam int N_IN     = 9;

	// folding threshold, sum ceiling, the "no leader" index and the reset value of the limit
	localparam logic [RATING_W-1:0] FOLD_LIMIT = 12'd1000;
	localparam logic [SUM_W-1:0]    SUM_MAX    = 13'h1FFF;
	localparam logic [IDX_W-1:0]    NO_ENTRY   = 4'hF;
	localparam logic [IDX_W-1:0]    MAX_RESET  = 4'd10;

	// input word
	typedef struct packed {
		logic                       restart;
		logic signed [RATING_W-1:0] rating_0;
		logic signed [RATING_W-1:0] rating_1;
		logic signed [RATING_W-1:0] rating_2;
		logic signed [RATING_W-1:0] rating_3;
		logic signed [RATING_W-1:0] rating_4;
		logic signed [RATING_W-1:0] rating_5;
		logic signed [RATING_W-1:0] rating_6;
		logic signed [RATING_W-1:0] rating_7;
		logic signed [RATING_W-1:0] rating_8;
	} in_word_t;

	// result word
	typedef struct packed {
		logic [IDX_W-1:0]  entry_index;
		logic [SUM_W-1:0]  trimmed_sum;
		logic [MEAN_W-1:0] mean_hundredths;
		logic [FOLD_W-1:0] middle_value;
		logic              is_new_best;
		logic [IDX_W-1:0]  leader_index;
		logic [MEAN_W-1:0] leader_mean_hundredths;
		logic              won_by_tiebreak;
	} out_word_t;

	// tag that travels with each queued entry
	typedef struct packed {
		logic             clear;
		logic [IDX_W-1:0] index;
	} meta_t;

endpackage

// File: src/tmmb_chan_if.sv
// valid/ready channel carrying one word of a given type
interface tmmb_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: src/tmmb_queue.sv
// small register queue between the front and the back
module tmmb_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] rdata
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign rdata     = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end
endmodule

// File: src/tmmb_front.sv
// front end: entry counting, restart handling and rating folding
module tmmb_front
	import tmmb_pkg::*;
#(
	parameter int RATINGS = 9
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [IDX_W-1:0]                 cfg_wdata,
	tmmb_chan_if.sink                        item,
	input  logic                             queue_full,
	output logic                             push,
	output meta_t                            meta,
	output logic [RATINGS-1:0][FOLD_W-1:0]   fold
);
	logic [IDX_W-1:0] max_q;
	logic [IDX_W-1:0] count_q;
	logic             pending_clear_q;
	logic [IDX_W-1:0] count_eff;
	logic             take;
	logic             accept;
	logic [RATING_W-1:0] raw [N_IN];

	// absolute value, then one step down past the limit
	function automatic logic [FOLD_W-1:0] fold_rating(input logic [RATING_W-1:0] v);
		logic [RATING_W-1:0] mag;
		mag = v[RATING_W-1] ? (~v + 1'b1) : v;
		if (mag > FOLD_LIMIT) begin
			mag = mag - FOLD_LIMIT;
		end
		return mag[FOLD_W-1:0];
	endfunction

	assign item.ready = !queue_full;
	assign accept     = item.valid && item.ready;
	assign count_eff  = item.data.restart ? '0 : count_q;
	assign take       = (count_eff < max_q);
	assign push       = accept && take;

	// a restart on a dropped word still has to reach the leader state
	assign meta.clear = item.data.restart || pending_clear_q;
	assign meta.index = count_eff;

	// fold the ratings, missing ones read as zero
	always_comb begin
		raw[0] = item.data.rating_0;
		raw[1] = item.data.rating_1;
		raw[2] = item.data.rating_2;
		raw[3] = item.data.rating_3;
		raw[4] = item.data.rating_4;
		raw[5] = item.data.rating_5;
		raw[6] = item.data.rating_6;
		raw[7] = item.data.rating_7;
		raw[8] = item.data.rating_8;
		for (int i = 0; i < RATINGS; i++) begin
			if (i < N_IN) begin
				fold[i] = fold_rating(raw[i]);
			end else begin
				fold[i] = '0;
			end
		end
	end

	// limit register, entry count and deferred clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q           <= MAX_RESET;
			count_q         <= '0;
			pending_clear_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
			if (accept) begin
				if (take) begin
					count_q         <= count_eff + 1'b1;
					pending_clear_q <= 1'b0;
				end else begin
					count_q         <= count_eff;
					pending_clear_q <= pending_clear_q || item.data.restart;
				end
			end
		end
	end
endmodule

// File: src/tmmb_back.sv
// back end: rank sort, trimmed sum, leader tracking and mean
module tmmb_back
	import tmmb_pkg::*;
#(
	parameter int RATINGS = 9
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_valid,
	input  meta_t                          q_meta,
	input  logic [RATINGS-1:0][FOLD_W-1:0] q_fold,
	output logic                           pop,
	tmmb_chan_if.source                    result
);
	localparam int RANK_W = (RATINGS > 1) ? $clog2(RATINGS) : 1;
	localparam int MID    = RATINGS / 2;
	localparam int D      = RATINGS - 2;
	localparam int TOT_W  = FOLD_W + $clog2(RATINGS + 1);
	localparam int X_W    = SUM_W + 5;
	localparam int K      = 24;
	localparam int P_W    = X_W + K;
	localparam logic [K-1:0]      RECIP    = K'(((1 << K) + 2 * D - 1) / (2 * D));
	localparam logic [X_W-1:0]    TEN_X2   = X_W'(20);
	localparam logic [X_W-1:0]    ROUND_C  = X_W'(D);
	localparam logic [RANK_W-1:0] MIN_RANK = '0;
	localparam logic [RANK_W-1:0] MAX_RANK = RANK_W'(RATINGS - 1);
	localparam logic [RANK_W-1:0] MID_RANK = RANK_W'(MID);

	logic adv;

	// stage 1 signals
	logic [RATINGS-1:0][RANK_W-1:0] rank_c;
	logic                           valid_s1;
	meta_t                          meta_s1;
	logic [RATINGS-1:0][FOLD_W-1:0] vals_s1;
	logic [RATINGS-1:0][RANK_W-1:0] rank_s1;

	// stage 2 signals
	logic [FOLD_W-1:0] min_c, max_c, mid_c;
	logic [TOT_W-1:0]  total_c, trim_c;
	logic [SUM_W-1:0]  sat_c;
	logic              valid_s2;
	meta_t             meta_s2;
	logic [SUM_W-1:0]  sum_s2;
	logic [FOLD_W-1:0] median_s2;

	// stage 3 signals and leader state
	logic [SUM_W-1:0]  best_sum_q;
	logic [FOLD_W-1:0] best_median_q;
	logic [IDX_W-1:0]  best_entry_q;
	logic              tiebreak_q;
	logic [SUM_W-1:0]  base_sum;
	logic [FOLD_W-1:0] base_median;
	logic [IDX_W-1:0]  base_entry;
	logic              base_tie;
	logic              win_sum, win_tie;
	logic [X_W-1:0]    x_c;
	logic [P_W-1:0]    prod_c;
	logic              valid_s3;
	logic              clear_s3;
	logic              win_sum_s3;
	logic              new_best_s3;
	logic              tie_s3;
	logic [IDX_W-1:0]  index_s3;
	logic [IDX_W-1:0]  leader_s3;
	logic [SUM_W-1:0]  sum_s3;
	logic [FOLD_W-1:0] median_s3;
	logic [P_W-1:0]    prod_s3;

	// output register
	logic [MEAN_W-1:0] best_mean_q;
	logic [MEAN_W-1:0] mean_c, lead_mean_c;
	logic              out_valid_q;
	out_word_t         out_q;

	// whole pipe moves when the output register is free or drained
	assign adv = !out_valid_q || result.ready;
	assign pop = adv && q_valid;

	// rank of each rating, ties broken by position
	always_comb begin
		for (int i = 0; i < RATINGS; i++) begin
			rank_c[i] = '0;
			for (int j = 0; j < RATINGS; j++) begin
				if (j != i) begin
					if ((q_fold[j] < q_fold[i]) || ((q_fold[j] == q_fold[i]) && (j < i))) begin
						rank_c[i] = rank_c[i] + 1'b1;
					end
				end
			end
		end
	end

	// pick the extremes and the median by rank, trim and saturate
	always_comb begin
		min_c   = '0;
		max_c   = '0;
		mid_c   = '0;
		total_c = '0;
		for (int i = 0; i < RATINGS; i++) begin
			total_c = total_c + TOT_W'(vals_s1[i]);
			if (rank_s1[i] == MIN_RANK) begin
				min_c = min_c | vals_s1[i];
			end
			if (rank_s1[i] == MAX_RANK) begin
				max_c = max_c | vals_s1[i];
			end
			if (rank_s1[i] == MID_RANK) begin
				mid_c = mid_c | vals_s1[i];
			end
		end
		trim_c = total_c - TOT_W'(min_c) - TOT_W'(max_c);
		sat_c  = (trim_c > TOT_W'(SUM_MAX)) ? SUM_MAX : trim_c[SUM_W-1:0];
	end

	// compare against the leader, cleared first on restart
	always_comb begin
		base_sum    = meta_s2.clear ? '0 : best_sum_q;
		base_median = meta_s2.clear ? '0 : best_median_q;
		base_entry  = meta_s2.clear ? NO_ENTRY : best_entry_q;
		base_tie    = meta_s2.clear ? 1'b0 : tiebreak_q;
		win_sum     = (sum_s2 > base_sum);
		win_tie     = !win_sum && (sum_s2 == base_sum) && (median_s2 > base_median);
	end

	// rounded mean: (sum*20 + d) / (2d) by reciprocal multiply
	assign x_c    = X_W'(sum_s2) * TEN_X2 + ROUND_C;
	assign prod_c = {{K{1'b0}}, x_c} * {{X_W{1'b0}}, RECIP};

	// leader mean follows the entry whose sum took the lead
	assign mean_c      = prod_s3[K +: MEAN_W];
	assign lead_mean_c = win_sum_s3 ? mean_c : (clear_s3 ? '0 : best_mean_q);

	// valid bits, leader state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			valid_s2      <= 1'b0;
			valid_s3      <= 1'b0;
			out_valid_q   <= 1'b0;
			best_sum_q    <= '0;
			best_median_q <= '0;
			best_entry_q  <= NO_ENTRY;
			tiebreak_q    <= 1'b0;
			best_mean_q   <= '0;
		end else if (adv) begin
			valid_s1    <= q_valid;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
			if (valid_s2) begin
				if (win_sum) begin
					best_sum_q    <= sum_s2;
					best_median_q <= median_s2;
					best_entry_q  <= meta_s2.index;
					tiebreak_q    <= 1'b0;
				end else if (win_tie) begin
					best_sum_q    <= base_sum;
					best_median_q <= median_s2;
					best_entry_q  <= meta_s2.index;
					tiebreak_q    <= 1'b1;
				end else begin
					best_sum_q    <= base_sum;
					best_median_q <= base_median;
					best_entry_q  <= base_entry;
					tiebreak_q    <= base_tie;
				end
			end
			if (valid_s3) begin
				best_mean_q <= lead_mean_c;
			end
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s1 <= q_meta;
			vals_s1 <= q_fold;
			rank_s1 <= rank_c;

			meta_s2   <= meta_s1;
			sum_s2    <= sat_c;
			median_s2 <= mid_c;

			clear_s3    <= meta_s2.clear;
			win_sum_s3  <= win_sum;
			new_best_s3 <= win_sum || win_tie;
			tie_s3      <= win_sum ? 1'b0 : (win_tie ? 1'b1 : base_tie);
			index_s3    <= meta_s2.index;
			leader_s3   <= (win_sum || win_tie) ? meta_s2.index : base_entry;
			sum_s3      <= sum_s2;
			median_s3   <= median_s2;
			prod_s3     <= prod_c;

			out_q.entry_index            <= index_s3;
			out_q.trimmed_sum            <= sum_s3;
			out_q.mean_hundredths        <= mean_c;
			out_q.middle_value           <= median_s3;
			out_q.is_new_best            <= new_best_s3;
			out_q.leader_index           <= leader_s3;
			out_q.leader_mean_hundredths <= lead_mean_c;
			out_q.won_by_tiebreak        <= tie_s3;
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	// a new best is always the entry just reported
	a_new_best_is_leader: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.is_new_best) |-> (out_q.leader_index == out_q.entry_index))
		else $error("new best does not name its own entry");

	// a lead taken on the sum carries this entry's mean
	a_sum_win_mean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.is_new_best && !out_q.won_by_tiebreak)
		|-> (out_q.leader_mean_hundredths == out_q.mean_hundredths))
		else $error("leader mean differs from winning entry mean");

	// leader sum only drops through a restart
	a_best_sum_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && valid_s2 && !meta_s2.clear) |=> (best_sum_q >= $past(best_sum_q)))
		else $error("leader sum fell without a restart");

	// a stalled pipe keeps its third stage
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !adv) |=> (valid_s3 && $stable(prod_s3)))
		else $error("stage three changed while stalled");
endmodule

// File: src/trimmed_mean_median_best_of_nine_top.sv
// Scores words of nine ratings in tenths: each rating is folded (absolute
// value, then 1000 taken off once when above 1000), the extremes are trimmed,
// and the result gives the trimmed sum, its mean in hundredths rounded to
// nearest, the median, and the best entry since the last restart (higher
// sum wins, equal sum with higher median wins on tie-break). The block takes
// one word per cycle and gives one result per cycle unless the receiver holds
// back ready; a word is taken whenever the QUEUE_DEPTH-word queue between
// the front end and the back end has room, and a result passes through the
// queue, then the rank, trim, leader compare with mean multiply and output
// register stages in that order. Words beyond the max_movies limit are taken
// and give no result; a restart on such a word still clears the leader for
// the next counted word. cfg_we writes max_movies (reset value 10) and should
// only be used while the block is idle.
module trimmed_mean_median_best_of_nine_top
	import tmmb_pkg::*;
#(
	parameter int RATINGS     = 9,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_wdata,
	tmmb_chan_if.sink        item,
	tmmb_chan_if.source      result
);
	localparam int FOLD_BITS = RATINGS * FOLD_W;
	localparam int Q_W       = $bits(meta_t) + FOLD_BITS;

	logic                           queue_full;
	logic                           push;
	meta_t                          front_meta;
	logic [RATINGS-1:0][FOLD_W-1:0] front_fold;
	logic                           pop;
	logic                           q_valid;
	logic [Q_W-1:0]                 q_rdata;
	meta_t                          q_meta;
	logic [RATINGS-1:0][FOLD_W-1:0] q_fold;

	// front end
	tmmb_front #(.RATINGS(RATINGS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.item       (item),
		.queue_full (queue_full),
		.push       (push),
		.meta       (front_meta),
		.fold       (front_fold)
	);

	// decoupling queue
	tmmb_queue #(.WIDTH(Q_W), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wdata     ({front_meta, front_fold}),
		.full      (queue_full),
		.pop       (pop),
		.not_empty (q_valid),
		.rdata     (q_rdata)
	);

	assign q_meta = q_rdata[Q_W-1 -: $bits(meta_t)];
	assign q_fold = q_rdata[FOLD_BITS-1:0];

	// back end
	tmmb_back #(.RATINGS(RATINGS)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_meta  (q_meta),
		.q_fold  (q_fold),
		.pop     (pop),
		.result  (result)
	);
endmodule

// File: sim/trimmed_mean_median_best_of_nine_top_test.sv
`timescale 1ns / 1ps
// self-checking testbench for the trimmed mean and median scorer with leader tracking
module trimmed_mean_median_best_of_nine_top_test;
	import tmmb_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 24;
	localparam int TRIM_N        = N_IN - 2;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_wdata;

	tmmb_chan_if #(.T(in_word_t))  item_ch ();
	tmmb_chan_if #(.T(out_word_t)) result_ch ();

	trimmed_mean_median_best_of_nine_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.item     (item_ch),
		.result   (result_ch)
	);

	// scorer state mirrored by the testbench
	logic [IDX_W-1:0]  limit_m;
	logic [IDX_W-1:0]  count_m;
	logic [SUM_W-1:0]  lead_sum_m;
	logic [FOLD_W-1:0] lead_median_m;
	logic [IDX_W-1:0]  lead_entry_m;
	logic              tiebreak_m;

	out_word_t   expected_scores[$];
	int          scored_words = 0;
	int          fail_count   = 0;
	int unsigned cycle_count  = 0;
	bit          calm         = 1'b0;

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("trimmed_mean_median_best_of_nine_top regression: fail");
			$finish;
		end
	end

	function automatic int fold_rating(input logic signed [RATING_W-1:0] raw);
		int mag;
		mag = int'(raw);
		if (mag < 0)
			mag = -mag;
		if (mag > int'(FOLD_LIMIT))
			mag -= int'(FOLD_LIMIT);
		return mag;
	endfunction

	function automatic int mean_of(input int sum);
		return (sum * 20 + TRIM_N) / (2 * TRIM_N);
	endfunction

	function automatic void clear_leader();
		count_m       = '0;
		lead_sum_m    = '0;
		lead_median_m = '0;
		lead_entry_m  = NO_ENTRY;
		tiebreak_m    = 1'b0;
	endfunction

	// expected result of one accepted word, if it is counted
	task automatic score_word(input in_word_t w);
		int        r [N_IN];
		int        tmp;
		int        sum;
		int        med;
		out_word_t res;
		if (w.restart)
			clear_leader();
		if (count_m >= limit_m)
			return;
		r[0] = fold_rating(w.rating_0);
		r[1] = fold_rating(w.rating_1);
		r[2] = fold_rating(w.rating_2);
		r[3] = fold_rating(w.rating_3);
		r[4] = fold_rating(w.rating_4);
		r[5] = fold_rating(w.rating_5);
		r[6] = fold_rating(w.rating_6);
		r[7] = fold_rating(w.rating_7);
		r[8] = fold_rating(w.rating_8);
		// ascending sort
		for (int i = 0; i < N_IN - 1; i++) begin
			for (int j = 0; j < N_IN - 1 - i; j++) begin
				if (r[j] > r[j + 1]) begin
					tmp      = r[j];
					r[j]     = r[j + 1];
					r[j + 1] = tmp;
				end
			end
		end
		sum = 0;
		for (int i = 1; i < N_IN - 1; i++)
			sum += r[i];
		if (sum > int'(SUM_MAX))
			sum = int'(SUM_MAX);
		med = r[N_IN / 2];
		res.is_new_best = 1'b0;
		// leader update, median breaks a tie on sum
		if (sum > int'(lead_sum_m)) begin
			lead_sum_m      = SUM_W'(sum);
			lead_median_m   = FOLD_W'(med);
			lead_entry_m    = count_m;
			tiebreak_m      = 1'b0;
			res.is_new_best = 1'b1;
		end else if (sum == int'(lead_sum_m) && med > int'(lead_median_m)) begin
			lead_median_m   = FOLD_W'(med);
			lead_entry_m    = count_m;
			tiebreak_m      = 1'b1;
			res.is_new_best = 1'b1;
		end
		res.entry_index            = count_m;
		res.trimmed_sum            = SUM_W'(sum);
		res.mean_hundredths        = MEAN_W'(mean_of(sum));
		res.middle_value           = FOLD_W'(med);
		res.leader_index           = lead_entry_m;
		res.leader_mean_hundredths = MEAN_W'(mean_of(int'(lead_sum_m)));
		res.won_by_tiebreak        = tiebreak_m;
		count_m                    = count_m + 1'b1;
		expected_scores.push_back(res);
		scored_words++;
	endtask

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			fail_count++;
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		out_word_t want;
		out_word_t got;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = result_ch.data;
			if (expected_scores.size() == 0) begin
				$display("%0t: unexpected result word, expected none actual index %0d",
					$time, got.entry_index);
				fail_count++;
			end else begin
				want = expected_scores.pop_front();
				check_field("entry_index", int'(want.entry_index), int'(got.entry_index));
				check_field("trimmed_sum", int'(want.trimmed_sum), int'(got.trimmed_sum));
				check_field("mean_hundredths", int'(want.mean_hundredths),
					int'(got.mean_hundredths));
				check_field("middle_value", int'(want.middle_value),
					int'(got.middle_value));
				check_field("is_new_best", int'(want.is_new_best), int'(got.is_new_best));
				check_field("leader_index", int'(want.leader_index),
					int'(got.leader_index));
				check_field("leader_mean_hundredths", int'(want.leader_mean_hundredths),
					int'(got.leader_mean_hundredths));
				check_field("won_by_tiebreak", int'(want.won_by_tiebreak),
					int'(got.won_by_tiebreak));
			end
		end
	end

	// receiver back-pressure in random bursts
	initial begin
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!calm && $urandom_range(0, 3) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	function automatic in_word_t make_word(input bit rst, input int a0, input int a1,
		input int a2, input int a3, input int a4, input int a5, input int a6,
		input int a7, input int a8);
		in_word_t w;
		w.restart  = rst;
		w.rating_0 = RATING_W'(a0);
		w.rating_1 = RATING_W'(a1);
		w.rating_2 = RATING_W'(a2);
		w.rating_3 = RATING_W'(a3);
		w.rating_4 = RATING_W'(a4);
		w.rating_5 = RATING_W'(a5);
		w.rating_6 = RATING_W'(a6);
		w.rating_7 = RATING_W'(a7);
		w.rating_8 = RATING_W'(a8);
		return w;
	endfunction

	// rating mix: full range, near the fold, small values for ties, extremes
	function automatic int rand_rating();
		int sgn;
		sgn = $urandom_range(0, 1) ? -1 : 1;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return int'($urandom_range(0, 4095)) - 2048;
			4, 5:       return sgn * int'($urandom_range(990, 1010));
			6, 7:       return sgn * 10 * int'($urandom_range(0, 5));
			8: begin
				case ($urandom_range(0, 4))
					0:       return -2048;
					1:       return -2047;
					2:       return 2047;
					3:       return 1000;
					default: return 0;
				endcase
			end
			default:    return $urandom_range(0, 1048);
		endcase
	endfunction

	function automatic in_word_t rand_word(input bit rst);
		return make_word(rst, rand_rating(), rand_rating(), rand_rating(), rand_rating(),
			rand_rating(), rand_rating(), rand_rating(), rand_rating(), rand_rating());
	endfunction

	// one word to the block, with an optional gap in front
	task automatic send_word(input in_word_t w);
		if (!calm && $urandom_range(0, 3) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data  <= w;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		score_word(w);
	endtask

	// stop sending and wait for every expected result, then optionally let the pipe empty
	task automatic drain_results(input bit settle);
		item_ch.valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (expected_scores.size() != 0);
		if (settle)
			repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [IDX_W-1:0] value);
		drain_results(1'b1);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		limit_m = value;
	endtask

	// reset value of the limit, rating extremes, folding and tie-break
	task automatic test_reset_and_extremes();
		send_word(make_word(1'b1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_word(make_word(1'b0, 2047, 2047, 2047, 2047, 2047, 2047, 2047, 2047, 2047));
		send_word(make_word(1'b0, -2048, -2048, -2048, -2048, -2048, -2048, -2048, -2048,
			-2048));
		send_word(make_word(1'b0, -2047, -2047, -2047, -2047, -2047, -2047, -2047, -2047,
			-2047));
		send_word(make_word(1'b0, 1000, 1001, -1000, -1001, 999, -999, 0, 2000, -2000));
		// equal sums, then a higher median wins the tie
		send_word(make_word(1'b1, 0, 100, 100, 100, 100, 100, 100, 100, 500));
		send_word(make_word(1'b0, 900, 40, 40, 40, 140, 140, 140, 160, 0));
		send_word(make_word(1'b0, 0, 100, 100, 100, 100, 100, 100, 100, 500));
		send_word(make_word(1'b0, -2047, 5, 5, 5, 5, 5, 5, 5, 2047));
		send_word(make_word(1'b0, 800, 700, 600, 500, 400, 300, 200, 100, 0));
		send_word(make_word(1'b0, 1, 2, 3, 4, 5, 6, 7, 8, 9));
		send_word(make_word(1'b0, 1, 2, 3, 4, 5, 6, 7, 8, 9));
		send_word(make_word(1'b0, 2047, 2047, 2047, 2047, 2047, 2047, 2047, 2047, 2047));
		// one more word under the limit, then a restart
		send_word(make_word(1'b0, 300, 300, 300, 300, 300, 300, 300, 300, 300));
		send_word(make_word(1'b1, 300, 300, 300, 300, 300, 300, 300, 300, 300));
		send_word(make_word(1'b0, -1, 1, -1, 1, -1, 1, -1, 1, -1));
	endtask

	// zero limit, smallest and largest limits
	task automatic test_limit_register();
		write_limit(4'd0);
		send_word(rand_word(1'b1));
		send_word(rand_word(1'b0));
		send_word(rand_word(1'b1));
		write_limit(4'd1);
		send_word(rand_word(1'b1));
		send_word(rand_word(1'b0));
		send_word(rand_word(1'b1));
		write_limit(4'd15);
		send_word(rand_word(1'b1));
		repeat (17)
			send_word(rand_word(1'b0));
	endtask

	// random phases over several limits, with one full drain mid-phase
	task automatic test_random_phases();
		logic [IDX_W-1:0] limits [8];
		int               start;
		limits = '{4'd1, 4'd15, 4'd10, 4'd2, 4'd0, 4'd0, 4'd7, 4'd15};
		limits[4] = IDX_W'($urandom_range(1, 15));
		limits[5] = IDX_W'($urandom_range(1, 15));
		foreach (limits[p]) begin
			write_limit(limits[p]);
			start = scored_words;
			send_word(rand_word(1'b1));
			while (scored_words - start < 70) begin
				if (p == 2 && scored_words - start == 60)
					drain_results(1'b0);
				send_word(rand_word($urandom_range(0, limit_m + 2) == 0));
			end
		end
	endtask

	// back-to-back traffic with no idling on either side
	task automatic test_back_to_back();
		write_limit(4'd15);
		calm = 1'b1;
		repeat (150)
			send_word(rand_word($urandom_range(0, 13) == 0));
	endtask

	initial begin
		arst_n         <= 1'b0;
		cfg_we         <= 1'b0;
		cfg_wdata      <= '0;
		item_ch.valid  <= 1'b0;
		item_ch.data   <= '0;
		limit_m = MAX_RESET;
		clear_leader();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_and_extremes();
		test_limit_register();
		test_random_phases();
		test_back_to_back();

		drain_results(1'b1);
		if (fail_count == 0)
			$display("trimmed_mean_median_best_of_nine_top regression: pass");
		else
			$display("trimmed_mean_median_best_of_nine_top regression: fail");
		$finish;
	end

endmodule
